### src/cubic_joint_trajectory_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cubic joint trajectory unit
// Checks are clocked on clk and held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef CUBIC_JOINT_TRAJECTORY_UNIT_MACROS_SVH
`define CUBIC_JOINT_TRAJECTORY_UNIT_MACROS_SVH

// Same-cycle implication.
`define CJT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CJT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/cjt_pkg.sv
// ---------------------------------------------------------------------------
// cjt_pkg
// Shared constants, types and helpers of the cubic joint trajectory unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cjt_pkg;

  localparam int JOINTS     = 8;
  localparam int TIME_BITS  = 16;
  localparam int JIDX_W     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int ANGLE_W    = 16;
  localparam int COEF_W     = 64;
  localparam int COEF_SHIFT = 41;
  localparam int T2_W       = 2 * TIME_BITS;
  localparam int DEN_W      = 3 * TIME_BITS;
  localparam int NUMB_W     = ANGLE_W + 2 + COEF_SHIFT;
  localparam int NUM_W      = ((NUMB_W > DEN_W) ? NUMB_W : DEN_W) + 1;
  localparam int DCNT_W     = $clog2(NUM_W + 1);
  localparam int WIDE_W     = 128;
  localparam int LIMB_W     = 32;
  localparam int LIMBS      = WIDE_W / LIMB_W;
  localparam int LIDX_W     = $clog2(LIMBS);
  localparam int VEL_SHIFT  = 60;
  localparam int VEL_W      = 32;

  localparam logic [ANGLE_W-1:0] POS_MAX  = 16'd46080;
  localparam logic [LIMB_W-1:0]  VSCALE   = 32'd6258227;
  localparam logic [LIMB_W-1:0]  CUBE_MUL = 32'd3;
  localparam logic [VEL_W-1:0]   VEL_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [VEL_W-1:0]   VEL_NEG_SAT = 32'h8000_0000;

  typedef enum logic {
    OP_PLAN = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    MS_A2T  = 3'd0,
    MS_P2   = 3'd1,
    MS_A3T  = 3'd2,
    MS_N2   = 3'd3,
    MS_P3   = 3'd4,
    MS_V3   = 3'd5,
    MS_VSC  = 3'd6
  } mstep_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] base;
    logic [COEF_W-1:0]  sq;
    logic [COEF_W-1:0]  cu;
  } entry_t;

  function automatic logic [JIDX_W-1:0] joint_addr(input logic [2:0] j);
    return JIDX_W'(j);
  endfunction

endpackage

`default_nettype wire

### src/cubic_joint_trajectory_unit.sv
// ---------------------------------------------------------------------------
// cubic_joint_trajectory_unit
// Rest-to-rest cubic trajectory planner and evaluator for a set of joints.
// ---------------------------------------------------------------------------
// channel | handshake              | beat
// cmd     | cmd_valid / cmd_ready  | opcode, joint, start_angle, end_angle,
//         |                        | duration, time_now
// res     | res_valid / res_ready  | position, velocity, error
//
// One item at a time. A plan runs two divisions of NUM_W steps each in the
// restoring divider; an evaluate makes seven passes through the limb-serial
// multiplier. A zero-duration plan or an out-of-range joint skips both units.
// Reset clears all joints at once through valid bits; no clearing pass.
// A stalled res beat holds and one finished result may wait behind it;
// no cmd beat is taken until that waiting result reaches the res register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cubic_joint_trajectory_unit_macros.svh"

module cubic_joint_trajectory_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic               opcode,
  input  logic [2:0]         joint,
  input  logic [15:0]        start_angle,
  input  logic [15:0]        end_angle,
  input  logic [15:0]        duration,
  input  logic [15:0]        time_now,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [15:0]        position,
  output logic signed [31:0] velocity,
  output logic               error
);
  import cjt_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_READ  = 10'b00_0000_0010,
    S_T2    = 10'b00_0000_0100,
    S_T3    = 10'b00_0000_1000,
    S_DIV   = 10'b00_0001_0000,
    S_MUL   = 10'b00_0010_0000,
    S_SUM1  = 10'b00_0100_0000,
    S_SUM2  = 10'b00_1000_0000,
    S_FIN   = 10'b01_0000_0000,
    S_WRITE = 10'b10_0000_0000
  } state_t;

  state_t state;
  logic   out_pend;
  logic   unit_wait;
  logic   step;
  mstep_t mstep;

  logic                 cmd_acc;
  logic                 jvalid;
  logic [2:0]           joint_q;
  logic                 zero_dur;
  logic [ANGLE_W-1:0]   start_q;
  logic [ANGLE_W-1:0]   end_q;
  logic [ANGLE_W-1:0]   d_q;
  logic                 neg_q;
  logic [TIME_BITS-1:0] tdur;
  logic [TIME_BITS-1:0] tnow;
  logic [T2_W-1:0]      t2;
  logic [DEN_W-1:0]     t3;
  logic [NUM_W-1:0]     sq_q;
  logic [NUM_W-1:0]     cu_q;

  logic [ANGLE_W-1:0]   base_q;
  logic [COEF_W-1:0]    a2m;
  logic [COEF_W-1:0]    a3m;
  logic                 a2neg;
  logic                 a3neg;
  logic [WIDE_W-1:0]    m1, p2, nq, p3, v3, vp;
  logic [WIDE_W-1:0]    pos, vel;
  logic                 velneg;

  logic [ANGLE_W-1:0]   pos_res;
  logic [VEL_W-1:0]     vel_res;
  logic                 err_res;

  entry_t               rd_data;
  entry_t               wr_data;
  logic                 wr_en;
  logic [COEF_W-1:0]    sq_c, cu_c, cu_mag;

  logic                 mul_start, mul_done;
  logic [WIDE_W-1:0]    mul_a, mul_p;
  logic [LIMB_W-1:0]    mul_b;
  logic                 div_start, div_done;
  logic [NUM_W-1:0]     div_num, div_quo;
  logic [DEN_W-1:0]     div_den;
  logic [NUM_W-1:0]     d3, d2;

  logic [WIDE_W-1:0]    pos_rnd, pos_m;
  logic [WIDE_W:0]      vel_rnd, vel_m;
  logic [ANGLE_W-1:0]   pos_fin;
  logic [VEL_W-1:0]     vel_fin;

  // hold off new beats while a finished result still waits for the res register
  assign cmd_ready = (state == S_IDLE) && !out_pend;
  assign cmd_acc   = cmd_valid && cmd_ready;
  assign jvalid    = (32'(joint) < JOINTS);

  // ---- memory ----
  assign cu_mag = ((t3 >> COEF_W) != '0) ? '0 : COEF_W'(cu_q);
  assign sq_c   = neg_q ? COEF_W'(-COEF_W'(sq_q)) : COEF_W'(sq_q);
  assign cu_c   = neg_q ? cu_mag : -cu_mag;
  assign wr_data.base = zero_dur ? end_q : start_q;
  assign wr_data.sq   = zero_dur ? '0 : sq_c;
  assign wr_data.cu   = zero_dur ? '0 : cu_c;
  assign wr_en        = (state == S_WRITE);

  cjt_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (cmd_acc && (opcode == OP_EVAL)),
    .rd_addr (joint_addr(joint)),
    .wr_en   (wr_en),
    .wr_addr (joint_addr(joint_q)),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // ---- divider ----
  assign d3        = (NUM_W'(d_q) + NUM_W'({d_q, 1'b0})) << COEF_SHIFT;
  assign d2        = NUM_W'({d_q, 1'b0}) << COEF_SHIFT;
  assign div_start = (state == S_DIV) && !unit_wait;
  assign div_num   = step ? (d2 + NUM_W'(t3 >> 1)) : (d3 + NUM_W'(t2 >> 1));
  assign div_den   = step ? t3 : DEN_W'(t2);

  cjt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ---- multiplier ----
  assign mul_start = (state == S_MUL) && !unit_wait;

  always_comb begin
    mul_a = nq;
    mul_b = LIMB_W'(tnow);
    case (mstep)
      MS_A2T:  mul_a = WIDE_W'(a2m);
      MS_P2:   mul_a = m1;
      MS_A3T:  mul_a = WIDE_W'(a3m);
      MS_N2:   mul_a = nq;
      MS_P3:   mul_a = nq;
      MS_V3: begin
        mul_a = nq;
        mul_b = CUBE_MUL;
      end
      MS_VSC: begin
        mul_a = vel;
        mul_b = VSCALE;
      end
      default: mul_a = nq;
    endcase
  end

  cjt_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // ---- rounding and saturation ----
  assign pos_rnd = pos + (WIDE_W'(1) << (COEF_SHIFT - 1));
  assign pos_m   = pos_rnd >> COEF_SHIFT;
  assign vel_rnd = {1'b0, vp} + ((WIDE_W + 1)'(1) << (VEL_SHIFT - 1));
  assign vel_m   = vel_rnd >> VEL_SHIFT;

  always_comb begin
    if (pos[WIDE_W-1]) begin
      pos_fin = '0;
    end else if (pos_m > WIDE_W'(POS_MAX)) begin
      pos_fin = POS_MAX;
    end else begin
      pos_fin = pos_m[ANGLE_W-1:0];
    end
    if (velneg) begin
      if (vel_m > (WIDE_W + 1)'(VEL_NEG_SAT)) begin
        vel_fin = VEL_NEG_SAT;
      end else begin
        vel_fin = -vel_m[VEL_W-1:0];
      end
    end else begin
      if (vel_m > (WIDE_W + 1)'(VEL_POS_SAT)) begin
        vel_fin = VEL_POS_SAT;
      end else begin
        vel_fin = vel_m[VEL_W-1:0];
      end
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_pend  <= 1'b0;
      unit_wait <= 1'b0;
      step      <= 1'b0;
      mstep     <= MS_A2T;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            step  <= 1'b0;
            mstep <= MS_A2T;
            if (opcode == OP_EVAL) begin
              if (jvalid) begin
                state <= S_READ;
              end else begin
                out_pend <= 1'b1;
              end
            end else if (!jvalid) begin
              out_pend <= 1'b1;
            end else if (duration[TIME_BITS-1:0] == '0) begin
              state <= S_WRITE;
            end else begin
              state <= S_T2;
            end
          end
        end
        S_READ: state <= S_MUL;
        S_T2:   state <= S_T3;
        S_T3:   state <= S_DIV;
        S_DIV: begin
          if (!unit_wait) begin
            unit_wait <= 1'b1;
          end else if (div_done) begin
            unit_wait <= 1'b0;
            step      <= 1'b1;
            if (step) begin
              state <= S_WRITE;
            end
          end
        end
        S_MUL: begin
          if (!unit_wait) begin
            unit_wait <= 1'b1;
          end else if (mul_done) begin
            unit_wait <= 1'b0;
            case (mstep)
              MS_A2T:  mstep <= MS_P2;
              MS_P2:   mstep <= MS_A3T;
              MS_A3T:  mstep <= MS_N2;
              MS_N2:   mstep <= MS_P3;
              MS_P3:   mstep <= MS_V3;
              MS_V3: begin
                mstep <= MS_VSC;
                state <= S_SUM1;
              end
              MS_VSC:  state <= S_FIN;
              default: state <= S_FIN;
            endcase
          end
        end
        S_SUM1: state <= S_SUM2;
        S_SUM2: state <= S_MUL;
        S_FIN, S_WRITE: begin
          // hold the result while the previous beat is still pending
          if (!out_pend || (res_valid && res_ready)) begin
            state    <= S_IDLE;
            out_pend <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_pend && !(state == S_FIN || state == S_WRITE) &&
          (!res_valid || res_ready)) begin
        out_pend <= 1'b0;
      end
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      joint_q  <= joint;
      start_q  <= start_angle;
      end_q    <= end_angle;
      zero_dur <= (duration[TIME_BITS-1:0] == '0);
      neg_q    <= (end_angle < start_angle);
      d_q      <= (end_angle < start_angle) ? start_angle - end_angle
                                            : end_angle - start_angle;
      tdur     <= duration[TIME_BITS-1:0];
      tnow     <= time_now[TIME_BITS-1:0];
      pos_res  <= '0;
      vel_res  <= '0;
      err_res  <= (opcode == OP_PLAN) && (duration[TIME_BITS-1:0] == '0);
    end
    if (state == S_T2) begin
      t2 <= T2_W'(tdur) * T2_W'(tdur);
    end
    if (state == S_T3) begin
      t3 <= DEN_W'(t2) * DEN_W'(tdur);
    end
    if ((state == S_DIV) && unit_wait && div_done) begin
      if (step) begin
        cu_q <= div_quo;
      end else begin
        sq_q <= div_quo;
      end
    end
    if (state == S_READ) begin
      base_q <= rd_data.base;
      a2neg  <= rd_data.sq[COEF_W-1];
      a3neg  <= rd_data.cu[COEF_W-1];
      a2m    <= rd_data.sq[COEF_W-1] ? -rd_data.sq : rd_data.sq;
      a3m    <= rd_data.cu[COEF_W-1] ? -rd_data.cu : rd_data.cu;
    end
    if ((state == S_MUL) && unit_wait && mul_done) begin
      case (mstep)
        MS_A2T:  m1 <= mul_p;
        MS_P2:   p2 <= mul_p;
        MS_A3T:  nq <= mul_p;
        MS_N2:   nq <= mul_p;
        MS_P3:   p3 <= mul_p;
        MS_V3:   v3 <= mul_p;
        MS_VSC:  vp <= mul_p;
        default: vp <= mul_p;
      endcase
    end
    if (state == S_SUM1) begin
      pos <= (WIDE_W'(base_q) << COEF_SHIFT) + (a2neg ? -p2 : p2);
      vel <= (a2neg ? -(m1 << 1) : (m1 << 1)) + (a3neg ? -v3 : v3);
    end
    if (state == S_SUM2) begin
      pos    <= pos + (a3neg ? -p3 : p3);
      velneg <= vel[WIDE_W-1];
      vel    <= vel[WIDE_W-1] ? -vel : vel;
    end
    if (state == S_FIN) begin
      pos_res <= pos_fin;
      vel_res <= vel_fin;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_pend && (!res_valid || res_ready) &&
                 !(state == S_FIN || state == S_WRITE)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_pend && (!res_valid || res_ready) &&
        !(state == S_FIN || state == S_WRITE)) begin
      position <= pos_res;
      velocity <= vel_res;
      error    <= err_res;
    end
  end

  // ---- checks ----
  `CJT_ASSERT_IMPLY(a_err_zero, res_valid && error, (position == '0) && (velocity == '0), "error beat carries data")
  `CJT_ASSERT_IMPLY(a_pos_range, res_valid, position <= POS_MAX, "position out of range")
  `CJT_ASSERT_NEXT(a_one_item, cmd_valid && cmd_ready, !cmd_ready, "second item taken while busy")

endmodule

`default_nettype wire

### src/cjt_store.sv
// ---------------------------------------------------------------------------
// cjt_store
// Per-joint coefficient memory, registered read, valid bits for reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cjt_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [cjt_pkg::JIDX_W-1:0] rd_addr,
  input  logic                      wr_en,
  input  logic [cjt_pkg::JIDX_W-1:0] wr_addr,
  input  cjt_pkg::entry_t           wr_data,
  output cjt_pkg::entry_t           rd_data
);
  import cjt_pkg::*;

  entry_t            mem [JOINTS];
  logic [JOINTS-1:0] valid;
  entry_t            rd_q;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

### src/cjt_mul.sv
// ---------------------------------------------------------------------------
// cjt_mul
// Wide by 32-bit multiplier, one 32-bit limb per cycle, saturates on carry out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cjt_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cjt_pkg::WIDE_W-1:0]  a,
  input  logic [cjt_pkg::LIMB_W-1:0]  b,
  output logic                        done,
  output logic [cjt_pkg::WIDE_W-1:0]  p
);
  import cjt_pkg::*;

  logic                  busy;
  logic [LIDX_W-1:0]     idx;
  logic [WIDE_W-1:0]     a_q;
  logic [WIDE_W-1:0]     acc;
  logic [LIMB_W-1:0]     b_q;
  logic [LIMB_W-1:0]     carry;
  logic                  ovf;
  logic [2*LIMB_W-1:0]   prod;

  assign prod = (2*LIMB_W)'(a_q[LIMB_W-1:0]) * (2*LIMB_W)'(b_q) + (2*LIMB_W)'(carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 1'b1;
        if (idx == LIDX_W'(LIMBS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q   <= a;
      b_q   <= b;
      carry <= '0;
    end else if (busy) begin
      a_q   <= a_q >> LIMB_W;
      carry <= prod[2*LIMB_W-1:LIMB_W];
      acc   <= {prod[LIMB_W-1:0], acc[WIDE_W-1:LIMB_W]};
      ovf   <= (prod[2*LIMB_W-1:LIMB_W] != '0);
    end
  end

  assign p = ovf ? '1 : acc;

endmodule

`default_nettype wire

### src/cjt_div.sv
// ---------------------------------------------------------------------------
// cjt_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cjt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cjt_pkg::NUM_W-1:0]  num,
  input  logic [cjt_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [cjt_pkg::NUM_W-1:0]  quo
);
  import cjt_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    trial;
  logic              ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      rem   <= '0;
      quo   <= num;
    end else if (busy) begin
      // shift the dividend out of quo while quotient bits fill in
      rem <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
// ---------------------------------------------------------------------------
// Cubic joint trajectory unit testbench
// Drives plan and evaluate beats through the cmd channel and checks each res
// beat against a bit-exact fixed-point model of the trajectory store, under
// several sender and receiver idling patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cjt_pkg::*;

  localparam int NPHASE   = 4;
  localparam int N_RANDOM = 1200;
  localparam int IDLE_LIM = 5000;

  typedef struct {
    opcode_t     op;
    logic [2:0]  jnt;
    logic [15:0] sa;
    logic [15:0] ea;
    logic [15:0] dur;
    logic [15:0] tn;
    int          ph;
  } cmd_item_t;

  typedef struct {
    logic [15:0] pos;
    logic [31:0] vel;
    logic        err;
  } res_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  logic opcode = 1'b0;
  logic [2:0] joint = '0;
  logic [15:0] start_angle = '0, end_angle = '0, duration = '0, time_now = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic [15:0] position;
  logic signed [31:0] velocity;
  logic error;

  cubic_joint_trajectory_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [15:0] base_q[8];
  logic [63:0] sq_q[8];
  logic [63:0] cu_q[8];

  cmd_item_t pending_q[$];
  res_item_t expected_q[$];
  cmd_item_t cur;
  logic      cmd_taken = 1'b0;
  int        cur_phase = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        n_plan = 0, n_eval = 0, n_zero = 0, n_res = 0;
  logic [15:0] plan_dur[8];

  function automatic res_item_t apply_cmd(cmd_item_t c);
    res_item_t r;
    logic [63:0] d, t2, t3, sq, cu;
    logic neg;
    logic signed [255:0] a2, a3, tt, p, v, am, m;
    r = '{pos: '0, vel: '0, err: 1'b0};
    if (c.op == OP_PLAN) begin
      if (c.dur == 0) begin
        r.err = 1'b1;
        base_q[c.jnt] = c.ea;
        sq_q[c.jnt] = '0;
        cu_q[c.jnt] = '0;
      end else begin
        neg = c.ea < c.sa;
        d = neg ? 64'(c.sa - c.ea) : 64'(c.ea - c.sa);
        t2 = 64'(c.dur) * 64'(c.dur);
        t3 = t2 * 64'(c.dur);
        sq = (((3 * d) << COEF_SHIFT) + t2 / 2) / t2;
        cu = (((2 * d) << COEF_SHIFT) + t3 / 2) / t3;
        base_q[c.jnt] = c.sa;
        sq_q[c.jnt] = neg ? -sq : sq;
        cu_q[c.jnt] = neg ? cu : -cu;
      end
      return r;
    end
    a2 = $signed({{192{sq_q[c.jnt][63]}}, sq_q[c.jnt]});
    a3 = $signed({{192{cu_q[c.jnt][63]}}, cu_q[c.jnt]});
    tt = $signed({240'd0, c.tn});
    p = $signed({240'd0, base_q[c.jnt]}) * (256'sd1 <<< COEF_SHIFT)
        + a2 * tt * tt + a3 * tt * tt * tt;
    if (p >= 0) begin
      m = (p + (256'sd1 <<< 40)) >>> COEF_SHIFT;
      r.pos = (m > 46080) ? POS_MAX : m[15:0];
    end
    v = 256'sd2 * a2 * tt + 256'sd3 * a3 * tt * tt;
    am = (v < 0) ? -v : v;
    m = (am * 256'sd6258227 + (256'sd1 <<< 59)) >>> 60;
    if (v < 0)
      r.vel = (m > 256'sh8000_0000) ? VEL_NEG_SAT : -m[31:0];
    else
      r.vel = (m > 256'sh7FFF_FFFF) ? VEL_POS_SAT : m[31:0];
    return r;
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic int send_idle_pct(int ph);
    return (ph == 1) ? 65 : (ph == 3) ? 26 : 0;
  endfunction

  function automatic int recv_stall_pct(int ph);
    return (ph == 2) ? 65 : (ph == 3) ? 26 : 0;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst && (!cmd_valid || cmd_taken)) begin
      if (pending_q.size() > 0 && !roll(send_idle_pct(pending_q[0].ph))) begin
        cur = pending_q.pop_front();
        opcode <= cur.op;
        joint <= cur.jnt;
        start_angle <= cur.sa;
        end_angle <= cur.ea;
        duration <= cur.dur;
        time_now <= cur.tn;
        cur_phase <= cur.ph;
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
    res_ready <= !rst && !roll(recv_stall_pct(cur_phase));
  end

  // accept, predict and check
  always @(posedge clk) begin
    cmd_item_t c;
    res_item_t e;
    cmd_taken <= cmd_valid && cmd_ready;
    if (!rst) begin
      if (cmd_valid && cmd_ready) begin
        c = '{op: opcode_t'(opcode), jnt: joint, sa: start_angle, ea: end_angle,
              dur: duration, tn: time_now, ph: cur_phase};
        expected_q.push_back(apply_cmd(c));
        if (c.op == OP_PLAN) begin
          n_plan++;
          if (c.dur == 0) n_zero++;
        end else begin
          n_eval++;
        end
      end
      if (res_valid && res_ready) begin
        n_res++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected res beat: pos=%0d vel=%0d err=%0b",
                                         position, velocity, error);
        end else begin
          e = expected_q.pop_front();
          if (position !== e.pos || velocity !== e.vel || error !== e.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("res mismatch: exp pos=%0d vel=%0d err=%0b, got pos=%0d vel=%0d err=%0b",
                       e.pos, $signed(e.vel), e.err, position, velocity, error);
          end
        end
      end
      // watchdog on stalled progress
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready) ||
          (pending_q.size() == 0 && expected_q.size() == 0 && !cmd_valid))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIM) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIM);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic add_cmd(opcode_t op, int j, int sa, int ea, int dur, int tn, int ph);
    cmd_item_t c;
    c = '{op: op, jnt: 3'(j), sa: 16'(sa), ea: 16'(ea), dur: 16'(dur), tn: 16'(tn), ph: ph};
    if (op == OP_PLAN) plan_dur[c.jnt] = c.dur;
    pending_q.push_back(c);
  endtask

  function automatic int rand_angle();
    return roll(10) ? int'($urandom_range(65535, 0)) : int'($urandom_range(46080, 0));
  endfunction

  function automatic int rand_dur();
    int k;
    k = $urandom_range(99, 0);
    if (k < 4) return 0;
    if (k < 50) return $urandom_range(60, 1);
    if (k < 85) return $urandom_range(2000, 1);
    return $urandom_range(65535, 1);
  endfunction

  initial begin
    int ph, j, n, tmax;
    for (int i = 0; i < 8; i++) begin
      base_q[i] = '0; sq_q[i] = '0; cu_q[i] = '0; plan_dur[i] = '0;
    end
    // directed
    add_cmd(OP_EVAL, 5, 0, 0, 0, 65535, 0);
    add_cmd(OP_PLAN, 0, 0, 46080, 100, 0, 0);
    add_cmd(OP_EVAL, 0, 0, 0, 0, 0, 0);
    add_cmd(OP_EVAL, 0, 0, 0, 0, 50, 0);
    add_cmd(OP_EVAL, 0, 0, 0, 0, 100, 0);
    add_cmd(OP_EVAL, 0, 0, 0, 0, 130, 0);
    add_cmd(OP_EVAL, 0, 0, 0, 0, 65535, 0);
    add_cmd(OP_PLAN, 1, 46080, 0, 1, 0, 0);
    add_cmd(OP_EVAL, 1, 0, 0, 0, 1, 0);
    add_cmd(OP_EVAL, 1, 0, 0, 0, 2, 0);
    add_cmd(OP_EVAL, 1, 0, 0, 0, 65535, 0);
    add_cmd(OP_PLAN, 2, 65535, 0, 65535, 0, 0);
    add_cmd(OP_EVAL, 2, 0, 0, 0, 32768, 0);
    add_cmd(OP_EVAL, 2, 0, 0, 0, 65535, 0);
    add_cmd(OP_PLAN, 3, 0, 65535, 65535, 0, 0);
    add_cmd(OP_EVAL, 3, 0, 0, 0, 65535, 0);
    add_cmd(OP_PLAN, 7, 12345, 40000, 0, 65535, 0);
    add_cmd(OP_EVAL, 7, 0, 0, 0, 777, 0);
    add_cmd(OP_PLAN, 4, 20000, 20000, 500, 0, 0);
    add_cmd(OP_EVAL, 4, 0, 0, 0, 250, 0);
    add_cmd(OP_PLAN, 6, 65535, 65535, 0, 0, 0);
    add_cmd(OP_EVAL, 6, 0, 0, 0, 21845, 0);
    add_cmd(OP_PLAN, 5, 1000, 45000, 3, 0, 0);
    add_cmd(OP_EVAL, 5, 0, 0, 0, 3, 0);
    // random: mostly a plan followed by evaluations along its path
    n = 0;
    while (n < N_RANDOM) begin
      ph = n * NPHASE / N_RANDOM;
      j = $urandom_range(7, 0);
      if (roll(80)) begin
        add_cmd(OP_PLAN, j, rand_angle(), rand_angle(), rand_dur(),
                $urandom_range(65535, 0), ph);
        n++;
      end
      repeat ($urandom_range(4, 1)) begin
        if (roll(85)) begin
          tmax = plan_dur[j] + plan_dur[j] / 4 + 1;
          add_cmd(OP_EVAL, j, $urandom_range(65535, 0), $urandom_range(65535, 0),
                  $urandom_range(65535, 0), $urandom_range(tmax, 0), ph);
        end else begin
          add_cmd(OP_EVAL, $urandom_range(7, 0), 0, 0, 0, $urandom_range(65535, 0), ph);
        end
        n++;
      end
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0 && !cmd_valid && expected_q.size() == 0);
    repeat (300) @(posedge clk);
    $display("ran %0d plans (%0d of zero duration) and %0d evaluations, %0d results",
             n_plan, n_zero, n_eval, n_res);
    $display("idling phases: none, sender, receiver, both; %0d mismatches",
             mismatches + expected_q.size());
    if (mismatches == 0 && expected_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
